FILE: design/lopc_pkg.sv
// package for the lidar obstacle point cluster block
// constants, sine coefficients and helper widths; no dependencies
`timescale 1ns / 1ps
package lopc_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] REG_MIN_RANGE = 3'd0;
    localparam logic [2:0] REG_MAX_RANGE = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_ANGLE_START = 3'd3;
    localparam logic [2:0] REG_ANGLE_STEP = 3'd4;
    localparam logic [2:0] REG_CLUSTER_DIST = 3'd5;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;
endpackage

FILE: design/lopc_if.sv
// valid/ready channel interface with a generic payload type
// depends on nothing
`timescale 1ns / 1ps
interface lopc_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/lopc_ram.sv
// generic ram with one write port and one read port, registered read
// no dependencies
`timescale 1ns / 1ps
module lopc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/lidar_obstacle_point_cluster.sv
// lidar obstacle point cluster top level: gate, polar conversion, clustering
// depends on lopc_pkg, lopc_if, lopc_ram
//
// channel  | dir | payload                                              | transfer
// in_ch    | in  | range_mm, range_finite, end_of_scan                  | valid & ready
// out_ch   | out | centroid_x_mm, centroid_y_mm, member_count,          | valid & ready
//          |     | last_cluster, points_dropped                         |
// cfg      | in  | cfg_we, cfg_idx, cfg_data                            | cfg_we
//
// a stored point keeps the input busy after its transfer: one shared 32x32 multiplier
// runs the sine polynomial and the range scaling per axis, then a turn-around state;
// a dropped sample without end of scan is ready again the next cycle. end of scan
// runs the leader pass over the point ram: a read per seed, a read and distance test
// per untaken candidate, a skip per taken one, then a bit serial divide per centroid
// axis. reset sets control and config state only; a held result stalls only the pass.
`timescale 1ns / 1ps
module lidar_obstacle_point_cluster
    import lopc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    lopc_if.sink                 in_ch,
    lopc_if.source               out_ch
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ANG = 5'd1;
    localparam logic [4:0] S_X2 = 5'd2;
    localparam logic [4:0] S_P1 = 5'd3;
    localparam logic [4:0] S_P2 = 5'd4;
    localparam logic [4:0] S_P3 = 5'd5;
    localparam logic [4:0] S_SCALE = 5'd6;
    localparam logic [4:0] S_NEXTAX = 5'd7;
    localparam logic [4:0] S_SEEDRD = 5'd8;
    localparam logic [4:0] S_SEEDWT = 5'd9;
    localparam logic [4:0] S_CANDRD = 5'd10;
    localparam logic [4:0] S_CANDWT = 5'd11;
    localparam logic [4:0] S_DX = 5'd12;
    localparam logic [4:0] S_DY = 5'd13;
    localparam logic [4:0] S_CMP = 5'd14;
    localparam logic [4:0] S_DIV = 5'd15;
    localparam logic [4:0] S_OUT = 5'd16;
    localparam logic [4:0] S_SEEDNX = 5'd17;

    // configuration registers
    logic [14:0] min_reg, max_reg, thr_reg, dist_reg;
    logic [15:0] start_reg, step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= 15'd100;
            max_reg   <= 15'd10000;
            thr_reg   <= 15'd500;
            start_reg <= 16'h8000;
            step_reg  <= 16'd182;
            dist_reg  <= 15'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_MIN_RANGE:    min_reg <= cfg_data[14:0];
                REG_MAX_RANGE:    max_reg <= cfg_data[14:0];
                REG_THRESHOLD:    thr_reg <= cfg_data[14:0];
                REG_ANGLE_START:  start_reg <= cfg_data;
                REG_ANGLE_STEP:   step_reg <= cfg_data;
                REG_CLUSTER_DIST: dist_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    logic [4:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0] index_reg, index_next;
    logic        ovf_reg, ovf_next;
    logic        eos_reg, eos_next;
    logic [15:0] range_reg, range_next;
    logic [15:0] ang_reg, ang_next;
    logic        axis_reg, axis_next;     // 0: x (cos), 1: y (sin)
    logic        neg_reg, neg_next;
    logic [16:0] xq_reg, xq_next;
    logic [31:0] acc_reg, acc_next;       // x2 and polynomial terms
    logic [15:0] px_reg, px_next;
    logic [MAX_POINTS-1:0] taken_reg, taken_next;
    logic [AW-1:0] seed_reg, seed_next;
    logic [CW-1:0] cand_reg, cand_next;
    logic [15:0] sx0_reg, sx0_next, sy0_reg, sy0_next;
    logic [22:0] sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0] dx_reg, dx_next;
    logic [16:0] dyv_reg, dyv_next;
    logic [33:0] dsq_reg, dsq_next;
    // divider
    logic [5:0]  dstep_reg, dstep_next;
    logic        daxis_reg, daxis_next;
    logic [22:0] dq_reg, dq_next;
    logic [CW-1:0] drem_reg, drem_next;
    logic [15:0] qx_reg, qx_next;
    // output register
    logic        ovalid_reg, ovalid_next;
    logic [15:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [6:0]  on_reg, on_next;
    logic        olast_reg, olast_next, odrop_reg, odrop_next;

    // point ram
    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0] ramx_rd, ramy_rd, ramx_wd;

    lopc_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram_x (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ramx_wd),
        .raddr(ram_raddr), .rdata(ramx_rd));
    lopc_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ram_y (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(px_next),
        .raddr(ram_raddr), .rdata(ramy_rd));

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // sample gate
    logic keep;
    assign keep = in_ch.data.range_finite
        && (in_ch.data.range_mm >= {1'b0, min_reg})
        && (in_ch.data.range_mm <= {1'b0, max_reg})
        && (in_ch.data.range_mm < {1'b0, thr_reg})
        && (step_reg != 16'd0);

    assign in_ch.ready = (state_reg == S_IDLE);

    // fold of the angle to a quarter wave
    logic [15:0] fa;
    logic signed [16:0] fa_s, fq;
    always_comb
    begin
        fa = axis_reg ? ang_reg : ang_reg + 16'd16384;
        fa_s = {fa[15], fa};
        if (fa_s > 17'sd16384)
            fq = 17'sd32768 - fa_s;
        else if (fa_s < -17'sd16384)
            fq = -17'sd32768 - fa_s;
        else
            fq = fa_s;
    end

    logic [31:0] xn;
    logic [22:0] sum_sel;
    logic [15:0] sv;
    logic [15:0] coord;
    logic [16:0] rdx, rdy;
    logic [23:0] drem_try;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        index_next = index_reg;
        ovf_next = ovf_reg;
        eos_next = eos_reg;
        range_next = range_reg;
        ang_next = ang_reg;
        axis_next = axis_reg;
        neg_next = neg_reg;
        xq_next = xq_reg;
        acc_next = acc_reg;
        px_next = px_reg;
        taken_next = taken_reg;
        seed_next = seed_reg;
        cand_next = cand_reg;
        sx0_next = sx0_reg;
        sy0_next = sy0_reg;
        sumx_next = sumx_reg;
        sumy_next = sumy_reg;
        cnt_next = cnt_reg;
        dx_next = dx_reg;
        dyv_next = dyv_reg;
        dsq_next = dsq_reg;
        dstep_next = dstep_reg;
        daxis_next = daxis_reg;
        dq_next = dq_reg;
        drem_next = drem_reg;
        qx_next = qx_reg;
        ovalid_next = ovalid_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        on_next = on_reg;
        olast_next = olast_reg;
        odrop_next = odrop_reg;
        ram_we = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_raddr = seed_reg;
        ramx_wd = px_reg;
        mul_a = 32'd0;
        mul_b = 32'd0;
        xn = 32'd0;
        sv = 16'd0;
        coord = 16'd0;
        rdx = 17'd0;
        rdy = 17'd0;
        sum_sel = daxis_reg ? sumy_reg : sumx_reg;
        drem_try = 24'd0;

        if (ovalid_reg && out_ch.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    eos_next = in_ch.data.end_of_scan;
                    range_next = in_ch.data.range_mm;
                    index_next = index_reg + 16'd1;
                    seed_next = '0;
                    if (keep && count_reg == CW'(MAX_POINTS))
                        ovf_next = 1'b1;
                    if (keep && count_reg != CW'(MAX_POINTS))
                    begin
                        mul_a = {16'd0, index_reg};
                        mul_b = {16'd0, step_reg};
                        ang_next = start_reg + mul_p[15:0];
                        axis_next = 1'b0;
                        state_next = S_ANG;
                    end
                    else if (in_ch.data.end_of_scan)
                        state_next = (step_reg != 16'd0 && count_reg != '0)
                            ? S_SEEDRD : S_SEEDNX;
                end
            end
            // x = 2|q|, x2 = x*x >> 15
            S_ANG:
            begin
                neg_next = fq[16];
                xq_next = fq[16] ? 17'(-fq) << 1 : 17'(fq) << 1;
                state_next = S_X2;
            end
            S_X2:
            begin
                mul_a = {15'd0, xq_reg};
                mul_b = {15'd0, xq_reg};
                acc_next = mul_p[46:15];
                state_next = S_P1;
            end
            // r = B - (x2*C >> 15)
            S_P1:
            begin
                mul_a = acc_reg;
                mul_b = {16'd0, SIN_C};
                xn = 32'(SIN_B) - mul_p[46:15];
                acc_next = acc_reg;
                xq_next = xq_reg;
                dsq_next = {2'd0, xn};
                state_next = S_P2;
            end
            // r = A - (x2*r >> 15)
            S_P2:
            begin
                mul_a = acc_reg;
                mul_b = dsq_reg[31:0];
                acc_next = 32'(SIN_A) - mul_p[46:15];
                state_next = S_P3;
            end
            // s = x*r >> 15, saturated
            S_P3:
            begin
                mul_a = {15'd0, xq_reg};
                mul_b = acc_reg;
                acc_next = (mul_p[63:15] > 49'd32767) ? 32'd32767 : mul_p[46:15];
                state_next = S_SCALE;
            end
            // coordinate = range*|s| rounded half away from zero
            S_SCALE:
            begin
                mul_a = {16'd0, range_reg};
                mul_b = acc_reg;
                xn = mul_p[31:0] + 32'd16384;
                sv = xn[30:15];
                coord = neg_reg ? 16'(-sv) : sv;
                px_next = coord;
                if (axis_reg)
                begin
                    ram_we = 1'b1;
                    ramx_wd = px_reg;
                    count_next = count_reg + 1'b1;
                    state_next = S_NEXTAX;
                end
                else
                begin
                    axis_next = 1'b1;
                    state_next = S_ANG;
                end
            end
            S_NEXTAX:
            begin
                if (eos_reg)
                    state_next = (count_reg != '0) ? S_SEEDRD : S_SEEDNX;
                else
                    state_next = S_IDLE;
            end
            // leader pass: seed at seed_reg
            S_SEEDRD:
            begin
                if (CW'(seed_reg) >= count_reg || ({1'b0, seed_reg} == CW'(MAX_POINTS)))
                    state_next = S_SEEDNX;
                else if (taken_reg[seed_reg])
                begin
                    if (CW'(seed_reg) + 1'b1 >= count_reg)
                        state_next = S_SEEDNX;
                    else
                        seed_next = seed_reg + 1'b1;
                end
                else
                begin
                    ram_raddr = seed_reg;
                    taken_next[seed_reg] = 1'b1;
                    state_next = S_SEEDWT;
                end
            end
            S_SEEDWT:
            begin
                sx0_next = ramx_rd;
                sy0_next = ramy_rd;
                sumx_next = {{7{ramx_rd[15]}}, ramx_rd};
                sumy_next = {{7{ramy_rd[15]}}, ramy_rd};
                cnt_next = CW'(1);
                cand_next = CW'(seed_reg) + 1'b1;
                state_next = S_CANDRD;
            end
            S_CANDRD:
            begin
                if (cand_reg >= count_reg)
                begin
                    daxis_next = 1'b0;
                    dstep_next = '0;
                    state_next = S_DIV;
                end
                else if (taken_reg[cand_reg[AW-1:0]])
                    cand_next = cand_reg + 1'b1;
                else
                begin
                    ram_raddr = cand_reg[AW-1:0];
                    state_next = S_CANDWT;
                end
            end
            S_CANDWT:
            begin
                rdx = {sx0_reg[15], sx0_reg} - {ramx_rd[15], ramx_rd};
                rdy = {sy0_reg[15], sy0_reg} - {ramy_rd[15], ramy_rd};
                dx_next = ramx_rd;
                px_next = ramy_rd;
                acc_next = {15'd0, rdx[16] ? 17'(-rdx) : rdx};
                dyv_next = rdy[16] ? 17'(-rdy) : rdy;
                state_next = S_DX;
            end
            S_DX:
            begin
                mul_a = acc_reg;
                mul_b = acc_reg;
                dsq_next = {2'd0, mul_p[31:0]};
                state_next = S_DY;
            end
            S_DY:
            begin
                mul_a = {15'd0, dyv_reg};
                mul_b = {15'd0, dyv_reg};
                dsq_next = dsq_reg + {2'd0, mul_p[31:0]};
                state_next = S_CMP;
            end
            S_CMP:
            begin
                mul_a = {17'd0, dist_reg};
                mul_b = {17'd0, dist_reg};
                if (dsq_reg < {4'd0, mul_p[29:0]})
                begin
                    taken_next[cand_reg[AW-1:0]] = 1'b1;
                    sumx_next = sumx_reg + {{7{dx_reg[15]}}, dx_reg};
                    sumy_next = sumy_reg + {{7{px_reg[15]}}, px_reg};
                    cnt_next = cnt_reg + 1'b1;
                end
                cand_next = cand_reg + 1'b1;
                state_next = S_CANDRD;
            end
            // restoring divide of |sum| by count, one bit a cycle
            S_DIV:
            begin
                if (dstep_reg == 6'd0)
                begin
                    dq_next = sum_sel[22] ? 23'(-sum_sel) : sum_sel;
                    drem_next = '0;
                    dstep_next = 6'd1;
                end
                else if (dstep_reg <= 6'd23)
                begin
                    drem_try = 24'({drem_reg, dq_reg[22]});
                    dq_next = {dq_reg[21:0], 1'b0};
                    if (drem_try >= 24'(cnt_reg))
                    begin
                        drem_next = CW'(drem_try - 24'(cnt_reg));
                        dq_next[0] = 1'b1;
                    end
                    else
                        drem_next = CW'(drem_try);
                    dstep_next = dstep_reg + 6'd1;
                end
                else
                begin
                    sv = sum_sel[22] ? 16'(-dq_reg) : dq_reg[15:0];
                    dstep_next = '0;
                    if (!daxis_reg)
                    begin
                        qx_next = sv;
                        daxis_next = 1'b1;
                    end
                    else
                    begin
                        px_next = sv;
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    ox_next = qx_reg;
                    oy_next = px_reg;
                    on_next = 7'(cnt_reg);
                    odrop_next = ovf_reg;
                    // last if no untaken point remains after the seed
                    olast_next = 1'b1;
                    for (int k = 0; k < MAX_POINTS; k++)
                        if (k > int'(seed_reg) && CW'(k) < count_reg && !taken_reg[k])
                            olast_next = 1'b0;
                    if (olast_next)
                        state_next = S_SEEDNX;
                    else
                    begin
                        seed_next = seed_reg + 1'b1;
                        state_next = S_SEEDRD;
                    end
                end
            end
            // end of scan clear
            S_SEEDNX:
            begin
                taken_next = '0;
                count_next = '0;
                index_next = '0;
                ovf_next = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            index_reg <= '0;
            ovf_reg <= 1'b0;
            taken_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            index_reg <= index_next;
            ovf_reg <= ovf_next;
            taken_reg <= taken_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eos_reg <= eos_next;
        range_reg <= range_next;
        ang_reg <= ang_next;
        axis_reg <= axis_next;
        neg_reg <= neg_next;
        xq_reg <= xq_next;
        acc_reg <= acc_next;
        px_reg <= px_next;
        seed_reg <= seed_next;
        cand_reg <= cand_next;
        sx0_reg <= sx0_next;
        sy0_reg <= sy0_next;
        sumx_reg <= sumx_next;
        sumy_reg <= sumy_next;
        cnt_reg <= cnt_next;
        dx_reg <= dx_next;
        dyv_reg <= dyv_next;
        dsq_reg <= dsq_next;
        dstep_reg <= dstep_next;
        daxis_reg <= daxis_next;
        dq_reg <= dq_next;
        drem_reg <= drem_next;
        qx_reg <= qx_next;
        ox_reg <= ox_next;
        oy_reg <= oy_next;
        on_reg <= on_next;
        olast_reg <= olast_next;
        odrop_reg <= odrop_next;
    end

    // output port
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data.centroid_x_mm = ox_reg;
    assign out_ch.data.centroid_y_mm = oy_reg;
    assign out_ch.data.member_count = on_reg;
    assign out_ch.data.last_cluster = olast_reg;
    assign out_ch.data.points_dropped = odrop_reg;
endmodule

FILE: sim/tb_lidar_obstacle_point_cluster.sv
// testbench for lidar_obstacle_point_cluster: range gate, polar conversion, leader clustering
// depends on lopc_pkg, lopc_if and the block itself; self-checking against its own predictor
`timescale 1ns / 1ps
module tb_lidar_obstacle_point_cluster;
    import lopc_pkg::*;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_finite;
        logic        end_of_scan;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] centroid_x_mm;
        logic signed [15:0] centroid_y_mm;
        logic [6:0]         member_count;
        logic               last_cluster;
        logic               points_dropped;
    } centroid_t;

    typedef struct {
        int        range_mm;
        bit        finite;
        bit        eos;
        bit        typed;
        centroid_t result;
    } row_t;

    localparam int STORE_DEPTH = 64;
    localparam longint CYCLE_LIMIT = 3000000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]  cfg_data;

    lopc_if #(.payload_t(sample_t))   in_if ();
    lopc_if #(.payload_t(centroid_t)) out_if ();

    lidar_obstacle_point_cluster uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    // predictor copy of configuration and scan state
    int          range_lo_mm, range_hi_mm, threshold, cluster_dist;
    int          angle_start, angle_step;
    int          point_x[STORE_DEPTH];
    int          point_y[STORE_DEPTH];
    int          stored_points;
    logic [15:0] sample_index;
    bit          overflow_seen;

    centroid_t   centroid_queue[$];
    int          error_count;
    int          random_items;
    int          idle_mode;
    bit          hold_req;
    longint      cycle_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // q1.15 sine of a binary angle
    function automatic int q15_sine(input logic [15:0] bam);
        int a;
        int q;
        bit neg;
        longint unsigned x, x2, r, s;
        a = $signed(bam);
        if (a > 16384)
            q = 32768 - a;
        else if (a < -16384)
            q = -32768 - a;
        else
            q = a;
        neg = q < 0;
        x = longint'(neg ? -q : q) * 2;
        x2 = (x * x) >> 15;
        r = longint'(SIN_B) - ((x2 * longint'(SIN_C)) >> 15);
        r = longint'(SIN_A) - ((x2 * r) >> 15);
        s = (x * r) >> 15;
        if (s > 32767)
            s = 32767;
        return neg ? -int'(s) : int'(s);
    endfunction

    // range times trig, rounded half away from zero
    function automatic int scale_axis(input int range_mm, input int trig);
        bit neg;
        longint unsigned m;
        int v;
        neg = trig < 0;
        m = longint'(range_mm) * longint'(neg ? -trig : trig);
        v = int'((m + 16384) >> 15);
        return neg ? -v : v;
    endfunction

    function automatic void clear_scan();
        stored_points = 0;
        sample_index = '0;
        overflow_seen = 1'b0;
    endfunction

    // one sample through the predictor; queues the centroids it causes
    function automatic void predict_sample(input sample_t s);
        logic [15:0] ang;
        bit taken[STORE_DEPTH];
        longint limit_sq, dx, dy;
        int sx, sy, cnt, first_new;
        centroid_t c;
        if (s.range_finite && s.range_mm >= range_lo_mm && s.range_mm <= range_hi_mm &&
            s.range_mm < threshold && angle_step != 0)
        begin
            if (stored_points < STORE_DEPTH)
            begin
                ang = 16'(angle_start + int'(sample_index) * angle_step);
                point_x[stored_points] = scale_axis(s.range_mm, q15_sine(ang + 16'd16384));
                point_y[stored_points] = scale_axis(s.range_mm, q15_sine(ang));
                stored_points++;
            end
            else
                overflow_seen = 1'b1;
        end
        sample_index = sample_index + 16'd1;
        if (!s.end_of_scan)
            return;
        first_new = centroid_queue.size();
        if (angle_step != 0)
        begin
            limit_sq = longint'(cluster_dist) * cluster_dist;
            foreach (taken[k])
                taken[k] = 1'b0;
            for (int i = 0; i < stored_points; i++)
            begin
                if (taken[i])
                    continue;
                taken[i] = 1'b1;
                sx = point_x[i];
                sy = point_y[i];
                cnt = 1;
                for (int j = i + 1; j < stored_points; j++)
                begin
                    if (taken[j])
                        continue;
                    dx = longint'(point_x[i]) - point_x[j];
                    dy = longint'(point_y[i]) - point_y[j];
                    if (dx * dx + dy * dy < limit_sq)
                    begin
                        taken[j] = 1'b1;
                        sx += point_x[j];
                        sy += point_y[j];
                        cnt++;
                    end
                end
                c.centroid_x_mm = 16'(sx / cnt);
                c.centroid_y_mm = 16'(sy / cnt);
                c.member_count = 7'(cnt);
                c.last_cluster = 1'b0;
                c.points_dropped = overflow_seen;
                centroid_queue = {centroid_queue, c};
            end
            if (centroid_queue.size() > first_new)
                centroid_queue[centroid_queue.size() - 1].last_cluster = 1'b1;
        end
        clear_scan();
    endfunction

    // config write, mirrored into the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= 16'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_RANGE:    range_lo_mm = value & 16'h7fff;
            REG_MAX_RANGE:    range_hi_mm = value & 16'h7fff;
            REG_THRESHOLD:    threshold = value & 16'h7fff;
            REG_ANGLE_START:  angle_start = int'($signed(16'(value)));
            REG_ANGLE_STEP:   angle_step = int'($signed(16'(value)));
            REG_CLUSTER_DIST: cluster_dist = value & 16'h7fff;
            default: ;
        endcase
    endtask

    // wait until the block has gone quiet before touching registers
    task automatic wait_idle();
        while (centroid_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // one sample transfer; typed rows replace the predicted result
    task automatic send_sample(input sample_t s, input bit typed, input centroid_t typed_res);
        int pct;
        bit rdy;
        pct = (idle_mode == 0) ? 12 : (idle_mode == 1) ? 65 : 0;
        while ($urandom_range(99) < pct)
            @(negedge clk);
        @(negedge clk);
        in_if.valid <= 1'b1;
        in_if.data <= s;
        do
        begin
            #1;
            rdy = in_if.ready;
            @(posedge clk);
            if (!rdy)
                @(negedge clk);
        end
        while (!rdy);
        predict_sample(s);
        if (typed)
            centroid_queue[centroid_queue.size() - 1] = typed_res;
        @(negedge clk);
        in_if.valid <= 1'b0;
    endtask

    // random scan: mostly qualifying ranges so that clusters form
    task automatic random_scan(input int n_samples);
        sample_t s;
        int lo, hi;
        centroid_t none;
        none = '0;
        lo = range_lo_mm;
        hi = (range_hi_mm < threshold - 1) ? range_hi_mm : threshold - 1;
        for (int i = 0; i < n_samples; i++)
        begin
            if (lo <= hi && $urandom_range(99) < 80)
                s.range_mm = 16'($urandom_range(hi, lo));
            else
                s.range_mm = 16'($urandom_range(65535));
            s.range_finite = $urandom_range(99) < 92;
            s.end_of_scan = (i == n_samples - 1);
            send_sample(s, 1'b0, none);
            random_items++;
            idle_mode = (random_items < 80) ? 0 : (random_items < 160) ? 1 : 2;
        end
    endtask

    // receiver: random stalls, with one long hold-off on request
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_if.ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_mode == 0)
                out_if.ready <= $urandom_range(99) >= 65;
            else if (idle_mode == 1)
                out_if.ready <= $urandom_range(99) >= 12;
            else
                out_if.ready <= 1'b1;
        end
    end

    // result monitor: compare each transfer with the oldest expected centroid
    initial
    begin
        centroid_t got, want;
        bit v, r;
        forever
        begin
            @(negedge clk);
            #1;
            v = out_if.valid;
            r = out_if.ready;
            got = out_if.data;
            @(posedge clk);
            if (v === 1'b1 && r === 1'b1)
            begin
                if (centroid_queue.size() == 0)
                begin
                    $display("%0t: centroid expected none actual %p", $time, got);
                    error_count++;
                end
                else
                begin
                    want = centroid_queue.pop_front();
                    if (got.centroid_x_mm !== want.centroid_x_mm)
                    begin
                        $display("%0t: x expected %0d actual %0d", $time,
                                 want.centroid_x_mm, got.centroid_x_mm);
                        error_count++;
                    end
                    if (got.centroid_y_mm !== want.centroid_y_mm)
                    begin
                        $display("%0t: y expected %0d actual %0d", $time,
                                 want.centroid_y_mm, got.centroid_y_mm);
                        error_count++;
                    end
                    if (got.member_count !== want.member_count)
                    begin
                        $display("%0t: count expected %0d actual %0d", $time,
                                 want.member_count, got.member_count);
                        error_count++;
                    end
                    if (got.last_cluster !== want.last_cluster)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time,
                                 want.last_cluster, got.last_cluster);
                        error_count++;
                    end
                    if (got.points_dropped !== want.points_dropped)
                    begin
                        $display("%0t: dropped expected %0b actual %0b", $time,
                                 want.points_dropped, got.points_dropped);
                        error_count++;
                    end
                end
            end
        end
    end

    // main sequence
    initial
    begin
        row_t rows[$];
        row_t rw;
        sample_t s;
        int wait_cycles;
        cycle_count = 0;
        error_count = 0;
        random_items = 0;
        idle_mode = 0;
        hold_req = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        rst_n = 1'b0;
        range_lo_mm = 100;
        range_hi_mm = 10000;
        threshold = 500;
        angle_start = -32768;
        angle_step = 182;
        cluster_dist = 200;
        clear_scan();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed samples under reset settings
        rows = '{
            '{0, 1, 0, 0, '0},          // below minimum
            '{65535, 1, 0, 0, '0},      // far beyond maximum
            '{300, 0, 0, 0, '0},        // not finite
            '{99, 1, 0, 0, '0},
            '{10001, 1, 0, 0, '0},
            '{500, 1, 0, 0, '0},        // at threshold, dropped: no obstacle
            '{10000, 1, 1, 0, '0},      // empty scan ends quietly
            '{300, 1, 1, 1, '{-16'sd300, 16'sd0, 7'd1, 1'b1, 1'b0}},
            '{100, 1, 0, 0, '0},
            '{499, 1, 0, 0, '0},
            '{250, 1, 0, 0, '0},
            '{260, 1, 0, 0, '0},
            '{32768, 1, 0, 0, '0},
            '{480, 1, 1, 0, '0}
        };
        foreach (rows[i])
        begin
            rw = rows[i];
            s.range_mm = 16'(rw.range_mm);
            s.range_finite = rw.finite;
            s.end_of_scan = rw.eos;
            send_sample(s, rw.typed, rw.result);
        end
        repeat (3) random_scan($urandom_range(12, 4));

        // wide-open settings, everything merges; long receiver hold-off
        wait_idle();
        write_reg(REG_MIN_RANGE, 0);
        write_reg(REG_MAX_RANGE, 32767);
        write_reg(REG_THRESHOLD, 32767);
        write_reg(REG_ANGLE_START, 0);
        write_reg(REG_ANGLE_STEP, 1);
        write_reg(REG_CLUSTER_DIST, 32767);
        hold_req = 1'b1;
        repeat (4) random_scan($urandom_range(14, 3));

        // zero cluster distance, half-turn step
        wait_idle();
        write_reg(REG_MIN_RANGE, 50);
        write_reg(REG_MAX_RANGE, 3000);
        write_reg(REG_THRESHOLD, 2000);
        write_reg(REG_ANGLE_START, 16384);
        write_reg(REG_ANGLE_STEP, -32768);
        write_reg(REG_CLUSTER_DIST, 0);
        repeat (4) random_scan($urandom_range(12, 2));

        // store overflow scan, then normal scans
        wait_idle();
        write_reg(REG_MIN_RANGE, 100);
        write_reg(REG_MAX_RANGE, 30000);
        write_reg(REG_THRESHOLD, 32767);
        write_reg(REG_ANGLE_START, -32768);
        write_reg(REG_ANGLE_STEP, 32767);
        write_reg(REG_CLUSTER_DIST, 500);
        random_scan(90);
        repeat (3) random_scan($urandom_range(10, 2));

        // zero step: no points, no results
        wait_idle();
        write_reg(REG_MIN_RANGE, 200);
        write_reg(REG_MAX_RANGE, 1000);
        write_reg(REG_THRESHOLD, 800);
        write_reg(REG_ANGLE_START, 12345);
        write_reg(REG_ANGLE_STEP, 0);
        write_reg(REG_CLUSTER_DIST, 300);
        repeat (3) random_scan($urandom_range(8, 2));

        // mid settings, negative step
        wait_idle();
        write_reg(REG_MIN_RANGE, 1000);
        write_reg(REG_MAX_RANGE, 20000);
        write_reg(REG_THRESHOLD, 15000);
        write_reg(REG_ANGLE_START, -20000);
        write_reg(REG_ANGLE_STEP, -700);
        write_reg(REG_CLUSTER_DIST, 1500);
        while (random_items < 216)
            random_scan($urandom_range(14, 2));

        // drain
        wait_cycles = 0;
        while (centroid_queue.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (500) @(posedge clk);
        if (error_count == 0 && centroid_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
